FILE: design/spq_pkg.sv
// Package for the sorted priority queue: sizes, command and status codes,
// and the transaction and entry structs. It has no dependencies.
`default_nettype none
package spq_pkg;

  // Queue geometry.
  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // Fixed field widths of the transactions.
  localparam int CMD_W   = 1;
  localparam int FIELD_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] item_key;
    logic [FIELD_W-1:0] item_payload;
  } spq_in_t;

  // Result transaction.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] out_key;
    logic [FIELD_W-1:0] out_payload;
    logic               front_valid;
    logic [FIELD_W-1:0] front_key;
    logic [FIELD_W-1:0] front_payload;
    logic [COUNT_W-1:0] entry_count;
  } spq_out_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } spq_entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage
`default_nettype wire

FILE: design/spq_cell.sv
// One cell of the sorted chain: holds a single entry, compares it against
// the broadcast key and shifts with its neighbors. Depends on spq_pkg.
`default_nettype none
module spq_cell import spq_pkg::*; (
  input  wire logic       clk,
  input  wire spq_ctl_t   ctl,
  input  wire logic       occ,
  input  wire spq_entry_t new_entry,
  input  wire spq_entry_t prev_entry,
  input  wire logic       prev_lt,
  input  wire spq_entry_t next_entry,
  output spq_entry_t      entry,
  output logic            lt
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // A held entry with a strictly smaller key stays ahead of the new one.
  assign lt    = occ && (entry_r.key < new_entry.key);
  assign entry = entry_r;

  // Keep, take the new entry, or shift from a neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq) begin
      if (lt) begin
        entry_nxt = entry_r;
      end else if (prev_lt) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctl.deq) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

FILE: design/sorted_priority_queue_unit.sv
// Sorted priority queue top level: a chain of spq_cell instances, the fill
// count and the result register. Depends on spq_pkg and spq_cell.
//
// The queue keeps up to DEPTH entries in ascending key order in a row of
// cells, cell 0 holding the front. For every command the new key is
// broadcast to all cells, each compares it with its own key, and the
// whole row shifts at the accepting edge, so busy never rises and a command
// may be issued in every cycle. The result of a command accepted at one
// edge appears with out_valid in the following cycle, for that cycle only;
// the receiver cannot hold it off. Equal keys leave last in, first out. An
// enqueue on a full queue is dropped with a full status, and a dequeue on an
// empty queue returns an empty status with zero key and payload.
`default_nettype none
module sorted_priority_queue_unit import spq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire spq_in_t in_data,
  output logic         out_valid,
  output spq_out_t     out_data
);

  logic             accept;
  logic             full;
  logic             empty;
  spq_ctl_t         ctl;
  spq_entry_t       new_entry;
  spq_entry_t       zero_entry;
  spq_entry_t       cells   [DEPTH];
  logic             lts     [DEPTH];
  logic             occ     [DEPTH];

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               valid_r, valid_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [FIELD_W-1:0] okey_r, okey_nxt;
  logic [FIELD_W-1:0] opay_r, opay_nxt;

  // No command ever holds the unit busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign zero_entry        = '0;
  assign new_entry.key     = KEY_BITS'(in_data.item_key);
  assign new_entry.payload = PAYLOAD_BITS'(in_data.item_payload);

  // Operation seen by the cells; dropped commands leave the row alone.
  assign ctl.enq = accept && (in_data.cmd == CMD_ENQ) && !full;
  assign ctl.deq = accept && (in_data.cmd == CMD_DEQ) && !empty;

  // The chain of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);
    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .new_entry  (new_entry),
      .prev_entry ((i == 0) ? zero_entry : cells[(i == 0) ? 0 : i - 1]),
      .prev_lt    ((i == 0) ? 1'b1 : lts[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == DEPTH - 1) ? zero_entry : cells[(i == DEPTH - 1) ? i : i + 1]),
      .entry      (cells[i]),
      .lt         (lts[i])
    );
  end

  // Fill count and result register.
  always_comb begin
    count_nxt  = count_r;
    valid_nxt  = accept;
    status_nxt = STATUS_OK;
    okey_nxt   = '0;
    opay_nxt   = '0;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
      okey_nxt  = FIELD_W'(cells[0].key);
      opay_nxt  = FIELD_W'(cells[0].payload);
    end
    if (accept && (in_data.cmd == CMD_ENQ) && full) begin
      status_nxt = STATUS_FULL;
    end else if (accept && (in_data.cmd == CMD_DEQ) && empty) begin
      status_nxt = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    okey_r   <= okey_nxt;
    opay_r   <= opay_nxt;
  end

  // The front after the step is already in cell 0 when the result shows.
  assign out_valid              = valid_r;
  assign out_data.status        = status_r;
  assign out_data.out_key       = okey_r;
  assign out_data.out_payload   = opay_r;
  assign out_data.front_valid   = !empty;
  assign out_data.front_key     = empty ? '0 : FIELD_W'(cells[0].key);
  assign out_data.front_payload = empty ? '0 : FIELD_W'(cells[0].payload);
  assign out_data.entry_count   = COUNT_W'(count_r);

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // Every accepted command yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command produced no result");

  // A stored enqueue raises the count by one.
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.enq |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not raise the count");

  // The two front cells stay in key order.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cells[0].key <= cells[1].key))
    else $error("front cells out of order");

endmodule
`default_nettype wire
